// File: rtl/core/x86dec_pkg.sv
// Types, opcode table and operand decode functions for the 16-bit x86 decoder.
// Used by x86_16bit_instruction_decoder; depends on nothing else.
`default_nettype none

package x86dec_pkg;

	typedef enum logic [6:0] {
		MN_AAA, MN_AAD, MN_AAM, MN_AAS, MN_ADC, MN_ADD, MN_AND, MN_CALL, MN_CBW,
		MN_CLC, MN_CLD, MN_CLI, MN_CMC, MN_CMP, MN_CMPSB, MN_CMPSW, MN_CWD,
		MN_DAA, MN_DAS, MN_DEC, MN_DIV, MN_HLT, MN_IDIV, MN_IMUL, MN_IN, MN_INC,
		MN_INT, MN_INTO, MN_INT3, MN_IRET, MN_JA, MN_JAE, MN_JB, MN_JBE, MN_JC,
		MN_JCXZ, MN_JE, MN_JG, MN_JGE, MN_JL, MN_JLE, MN_JMP, MN_JNA, MN_JNAE,
		MN_JNB, MN_JNBE, MN_JNC, MN_JNE, MN_JNG, MN_JNGE, MN_JNL, MN_JNLE, MN_JNO,
		MN_JNP, MN_JNS, MN_JNZ, MN_JO, MN_JP, MN_JPE, MN_JPO, MN_JS, MN_JZ,
		MN_LAHF, MN_LDS, MN_LEA, MN_LES, MN_LODSB, MN_LODSW, MN_LOOP, MN_LOOPE,
		MN_LOOPNE, MN_LOOPNZ, MN_LOOPZ, MN_MOV, MN_MOVSB, MN_MOVSW, MN_MUL,
		MN_NEG, MN_NOP, MN_NOT, MN_OR, MN_OUT, MN_POP, MN_POPA, MN_POPF, MN_PUSH,
		MN_PUSHA, MN_PUSHF, MN_RCL, MN_RCR, MN_RET, MN_RETF, MN_ROL, MN_ROR,
		MN_SAHF, MN_SAL, MN_SAR, MN_SBB, MN_SCASB, MN_SCASW, MN_SHL, MN_SHR,
		MN_STC, MN_STD, MN_STI, MN_STOSB, MN_STOSW, MN_SUB, MN_TEST, MN_XCHG,
		MN_XLATB, MN_XOR, MN_BAD
	} mn_t;

	// Operand forms; register forms are 16 plus the register code
	typedef enum logic [4:0] {
		OP_NO = 5'd0, OP_SM = 5'd1, OP_E8 = 5'd2, OP_E16 = 5'd3, OP_G8 = 5'd4,
		OP_G16 = 5'd5, OP_IU8 = 5'd6, OP_IS8 = 5'd7, OP_IZ16 = 5'd8, OP_IS16 = 5'd9,
		OP_SR = 5'd10, OP_R8 = 5'd11, OP_R16 = 5'd12, OP_MOF = 5'd13,
		OP_AX = 5'd16, OP_BX = 5'd17, OP_CX = 5'd18, OP_DX = 5'd19,
		OP_AL = 5'd20, OP_BL = 5'd21, OP_CL = 5'd22, OP_DL = 5'd23,
		OP_AH = 5'd24, OP_BH = 5'd25, OP_CH = 5'd26, OP_DH = 5'd27,
		OP_SI = 5'd28, OP_DI = 5'd29, OP_BP = 5'd30, OP_SP = 5'd31
	} spec_t;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_REG  = 2'd1;
	localparam logic [1:0] KIND_IMM  = 2'd2;
	localparam logic [1:0] KIND_MEM  = 2'd3;

	localparam logic [4:0] NOREG = 5'd16;
	localparam logic [1:0] SLOT_THIRD = 2'd2;
	localparam int NUM_SLOTS = 3;

	typedef struct packed {
		logic [7:0]  opcode_byte;
		logic [7:0]  next_byte;
		logic [31:0] following_bytes;
		logic [31:0] instr_address;
	} in_t;

	typedef struct packed {
		logic [6:0]         mnemonic;
		logic               is_jump;
		logic               ends_flow;
		logic [2:0]         length;
		logic [1:0]         slot;
		logic [1:0]         kind;
		logic [4:0]         base_reg;
		logic [4:0]         index_reg;
		logic signed [31:0] value;
		logic               last;
	} out_t;

	typedef struct packed {
		mn_t        mn;
		spec_t      d;
		spec_t      s;
		spec_t      t;
		logic [2:0] len;
		logic       jmp;
		logic       endf;
	} form_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  base;
		logic [4:0]  index;
		logic [31:0] value;
	} opnd_t;

	function automatic logic [4:0] bank8(input logic [2:0] i);
		logic [4:0] r;
		unique case (i)
			3'd0: r = 5'd4;
			3'd1: r = 5'd6;
			3'd2: r = 5'd7;
			3'd3: r = 5'd5;
			3'd4: r = 5'd8;
			3'd5: r = 5'd10;
			3'd6: r = 5'd11;
			default: r = 5'd9;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] bank16(input logic [2:0] i);
		logic [4:0] r;
		unique case (i)
			3'd0: r = 5'd0;
			3'd1: r = 5'd2;
			3'd2: r = 5'd3;
			3'd3: r = 5'd1;
			3'd4: r = 5'd15;
			3'd5: r = 5'd14;
			3'd6: r = 5'd12;
			default: r = 5'd13;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] mem_base(input logic [2:0] i);
		logic [4:0] r;
		unique case (i)
			3'd0, 3'd1, 3'd7: r = 5'd1;
			3'd4: r = 5'd12;
			3'd5: r = 5'd13;
			default: r = 5'd14;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] mem_index(input logic [2:0] i);
		logic [4:0] r;
		unique case (i)
			3'd0, 3'd2: r = 5'd12;
			3'd1, 3'd3: r = 5'd13;
			default: r = NOREG;
		endcase
		return r;
	endfunction

	function automatic spec_t reg16_spec(input logic [2:0] i);
		return spec_t'(5'd16 + bank16(i));
	endfunction

	function automatic spec_t reg8_spec(input logic [2:0] i);
		return spec_t'(5'd16 + bank8(i));
	endfunction

	function automatic mn_t alu_mn(input logic [2:0] i);
		mn_t m;
		unique case (i)
			3'd0: m = MN_ADD;
			3'd1: m = MN_OR;
			3'd2: m = MN_ADC;
			3'd3: m = MN_SBB;
			3'd4: m = MN_AND;
			3'd5: m = MN_SUB;
			3'd6: m = MN_XOR;
			default: m = MN_CMP;
		endcase
		return m;
	endfunction

	function automatic mn_t jcc_mn(input logic [3:0] i);
		mn_t m;
		unique case (i)
			4'h0: m = MN_JO;
			4'h1: m = MN_JNO;
			4'h2: m = MN_JB;
			4'h3: m = MN_JAE;
			4'h4: m = MN_JE;
			4'h5: m = MN_JNE;
			4'h6: m = MN_JBE;
			4'h7: m = MN_JA;
			4'h8: m = MN_JS;
			4'h9: m = MN_JNS;
			4'hA: m = MN_JP;
			4'hB: m = MN_JNP;
			4'hC: m = MN_JL;
			4'hD: m = MN_JGE;
			4'hE: m = MN_JLE;
			default: m = MN_JG;
		endcase
		return m;
	endfunction

	function automatic form_t mkf(input mn_t m, input spec_t d, input spec_t s,
			input logic [2:0] len);
		form_t f;
		f.mn = m;
		f.d = d;
		f.s = s;
		f.t = OP_SM;
		f.len = len;
		f.jmp = 1'b0;
		f.endf = 1'b0;
		return f;
	endfunction

	// Opcode table: mnemonic, operand forms, base length, flow flags
	function automatic form_t get_form(input logic [7:0] op);
		form_t f;
		f = mkf(MN_BAD, OP_NO, OP_NO, 3'd1);
		if (op[7:6] == 2'b00 && op[2:1] != 2'b11) begin
			unique case (op[2:0])
				3'd0: f = mkf(alu_mn(op[5:3]), OP_E8, OP_G8, 3'd2);
				3'd1: f = mkf(alu_mn(op[5:3]), OP_E16, OP_G16, 3'd2);
				3'd2: f = mkf(alu_mn(op[5:3]), OP_G8, OP_E8, 3'd2);
				3'd3: f = mkf(alu_mn(op[5:3]), OP_G16, OP_E16, 3'd2);
				3'd4: f = mkf(alu_mn(op[5:3]), OP_AL, OP_IU8, 3'd2);
				default: f = mkf(alu_mn(op[5:3]), OP_AX, OP_IZ16, 3'd3);
			endcase
		end else if (op[7:5] == 3'b010) begin
			unique case (op[4:3])
				2'd0: f = mkf(MN_INC, reg16_spec(op[2:0]), OP_NO, 3'd1);
				2'd1: f = mkf(MN_DEC, reg16_spec(op[2:0]), OP_NO, 3'd1);
				2'd2: f = mkf(MN_PUSH, reg16_spec(op[2:0]), OP_NO, 3'd1);
				default: f = mkf(MN_POP, reg16_spec(op[2:0]), OP_NO, 3'd1);
			endcase
		end else if (op[7:4] == 4'h7) begin
			f = mkf(jcc_mn(op[3:0]), OP_R8, OP_NO, 3'd2);
			f.jmp = 1'b1;
		end else if (op[7:3] == 5'b10110) begin
			f = mkf(MN_MOV, reg8_spec(op[2:0]), OP_IU8, 3'd2);
		end else if (op[7:3] == 5'b10111) begin
			f = mkf(MN_MOV, reg16_spec(op[2:0]), OP_IZ16, 3'd3);
		end else if (op[7:3] == 5'b10010 && op[2:0] != 3'd0) begin
			f = mkf(MN_XCHG, OP_AX, reg16_spec(op[2:0]), 3'd1);
		end else begin
			unique case (op) inside
				8'h06, 8'h0E, 8'h16, 8'h1E: f = mkf(MN_PUSH, OP_NO, OP_NO, 3'd1);
				8'h07, 8'h17, 8'h1F: f = mkf(MN_POP, OP_NO, OP_NO, 3'd1);
				8'h27: f = mkf(MN_DAA, OP_NO, OP_NO, 3'd1);
				8'h2E: f = mkf(MN_DAS, OP_NO, OP_NO, 3'd1);
				8'h37: f = mkf(MN_AAA, OP_NO, OP_NO, 3'd1);
				8'h3F: f = mkf(MN_AAS, OP_NO, OP_NO, 3'd1);
				8'h60: f = mkf(MN_PUSHA, OP_NO, OP_NO, 3'd1);
				8'h61: f = mkf(MN_POPA, OP_NO, OP_NO, 3'd1);
				8'h68: f = mkf(MN_PUSH, OP_IZ16, OP_NO, 3'd3);
				8'h69: begin
					f = mkf(MN_IMUL, OP_G16, OP_IZ16, 3'd4);
					f.t = OP_E16;
				end
				8'h6A: f = mkf(MN_PUSH, OP_IS8, OP_NO, 3'd2);
				8'h6B: begin
					f = mkf(MN_IMUL, OP_G16, OP_IS8, 3'd3);
					f.t = OP_E16;
				end
				8'h84: f = mkf(MN_TEST, OP_E8, OP_G8, 3'd2);
				8'h85: f = mkf(MN_TEST, OP_E16, OP_G16, 3'd2);
				8'h86: f = mkf(MN_XCHG, OP_G8, OP_E8, 3'd2);
				8'h87: f = mkf(MN_XCHG, OP_G16, OP_E16, 3'd2);
				8'h88: f = mkf(MN_MOV, OP_E8, OP_G8, 3'd2);
				8'h89: f = mkf(MN_MOV, OP_E16, OP_G16, 3'd2);
				8'h8A: f = mkf(MN_MOV, OP_G8, OP_E8, 3'd2);
				8'h8B: f = mkf(MN_MOV, OP_G16, OP_E16, 3'd2);
				8'h8C: f = mkf(MN_MOV, OP_E16, OP_SR, 3'd2);
				8'h8D: f = mkf(MN_LEA, OP_G16, OP_E16, 3'd2);
				8'h8E: f = mkf(MN_MOV, OP_SR, OP_E16, 3'd2);
				8'h8F: f = mkf(MN_POP, OP_E16, OP_NO, 3'd2);
				8'h90: f = mkf(MN_NOP, OP_NO, OP_NO, 3'd1);
				8'h9A: f = mkf(MN_CALL, OP_IZ16, OP_NO, 3'd3);
				8'h9C: f = mkf(MN_PUSHF, OP_NO, OP_NO, 3'd1);
				8'h9D: f = mkf(MN_POPF, OP_NO, OP_NO, 3'd1);
				8'h9E: f = mkf(MN_SAHF, OP_NO, OP_NO, 3'd1);
				8'h9F: f = mkf(MN_LAHF, OP_NO, OP_NO, 3'd1);
				8'hA0: f = mkf(MN_MOV, OP_AL, OP_MOF, 3'd3);
				8'hA1: f = mkf(MN_MOV, OP_AX, OP_MOF, 3'd3);
				8'hA2: f = mkf(MN_MOV, OP_MOF, OP_AL, 3'd3);
				8'hA3: f = mkf(MN_MOV, OP_MOF, OP_AX, 3'd3);
				8'hA4: f = mkf(MN_MOVSB, OP_NO, OP_NO, 3'd1);
				8'hA5: f = mkf(MN_MOVSW, OP_NO, OP_NO, 3'd1);
				8'hA6: f = mkf(MN_CMPSB, OP_NO, OP_NO, 3'd1);
				8'hA7: f = mkf(MN_CMPSW, OP_NO, OP_NO, 3'd1);
				8'hA8: f = mkf(MN_TEST, OP_AL, OP_IU8, 3'd2);
				8'hA9: f = mkf(MN_TEST, OP_AX, OP_IZ16, 3'd3);
				8'hAA: f = mkf(MN_STOSB, OP_NO, OP_NO, 3'd1);
				8'hAB: f = mkf(MN_STOSW, OP_NO, OP_NO, 3'd1);
				8'hAC: f = mkf(MN_LODSB, OP_NO, OP_NO, 3'd1);
				8'hAD: f = mkf(MN_LODSW, OP_NO, OP_NO, 3'd1);
				8'hAE: f = mkf(MN_SCASB, OP_NO, OP_NO, 3'd1);
				8'hAF: f = mkf(MN_SCASW, OP_NO, OP_NO, 3'd1);
				8'hC2, 8'hCA: begin
					f = mkf(op[3] ? MN_RETF : MN_RET, OP_IS16, OP_NO, 3'd3);
					f.endf = 1'b1;
				end
				8'hC3, 8'hCB: begin
					f = mkf(op[3] ? MN_RETF : MN_RET, OP_NO, OP_NO, 3'd1);
					f.endf = 1'b1;
				end
				8'hC4: f = mkf(MN_LES, OP_G16, OP_E16, 3'd2);
				8'hC5: f = mkf(MN_LDS, OP_G16, OP_E16, 3'd2);
				8'hC6: f = mkf(MN_MOV, OP_E8, OP_IU8, 3'd3);
				8'hC7: f = mkf(MN_MOV, OP_E16, OP_IS16, 3'd4);
				8'hCC: f = mkf(MN_INT3, OP_NO, OP_NO, 3'd1);
				8'hCD: f = mkf(MN_INT, OP_IU8, OP_NO, 3'd2);
				8'hCE: f = mkf(MN_INTO, OP_NO, OP_NO, 3'd1);
				8'hCF: f = mkf(MN_IRET, OP_NO, OP_NO, 3'd1);
				8'hD4: f = mkf(MN_AAM, OP_IU8, OP_NO, 3'd2);
				8'hD5: f = mkf(MN_AAD, OP_IU8, OP_NO, 3'd2);
				8'hD7: f = mkf(MN_XLATB, OP_NO, OP_NO, 3'd1);
				8'hE0, 8'hE1, 8'hE2, 8'hE3: begin
					unique case (op[1:0])
						2'd0: f = mkf(MN_LOOPNE, OP_R8, OP_NO, 3'd2);
						2'd1: f = mkf(MN_LOOPE, OP_R8, OP_NO, 3'd2);
						2'd2: f = mkf(MN_LOOP, OP_R8, OP_NO, 3'd2);
						default: f = mkf(MN_JCXZ, OP_R8, OP_NO, 3'd2);
					endcase
					f.jmp = 1'b1;
				end
				8'hE4: f = mkf(MN_IN, OP_AL, OP_IU8, 3'd2);
				8'hE5: f = mkf(MN_IN, OP_AX, OP_IU8, 3'd2);
				8'hE6: f = mkf(MN_OUT, OP_IU8, OP_AL, 3'd2);
				8'hE7: f = mkf(MN_OUT, OP_IU8, OP_AX, 3'd2);
				8'hE8: f = mkf(MN_CALL, OP_R16, OP_NO, 3'd3);
				8'hE9: begin
					f = mkf(MN_JMP, OP_R16, OP_NO, 3'd3);
					f.jmp = 1'b1;
					f.endf = 1'b1;
				end
				8'hEA: begin
					f = mkf(MN_JMP, OP_IZ16, OP_NO, 3'd3);
					f.jmp = 1'b1;
					f.endf = 1'b1;
				end
				8'hEB: begin
					f = mkf(MN_JMP, OP_R8, OP_NO, 3'd2);
					f.jmp = 1'b1;
					f.endf = 1'b1;
				end
				8'hEC: f = mkf(MN_IN, OP_AL, OP_DX, 3'd1);
				8'hED: f = mkf(MN_IN, OP_AX, OP_DX, 3'd1);
				8'hEE: f = mkf(MN_OUT, OP_DX, OP_AL, 3'd1);
				8'hEF: f = mkf(MN_OUT, OP_DX, OP_AX, 3'd1);
				8'hF4: f = mkf(MN_HLT, OP_NO, OP_NO, 3'd1);
				8'hF5: f = mkf(MN_CMC, OP_NO, OP_NO, 3'd1);
				8'hF8: f = mkf(MN_CLC, OP_NO, OP_NO, 3'd1);
				8'hF9: f = mkf(MN_STC, OP_NO, OP_NO, 3'd1);
				8'hFA: f = mkf(MN_CLI, OP_NO, OP_NO, 3'd1);
				8'hFB: f = mkf(MN_STI, OP_NO, OP_NO, 3'd1);
				8'hFC: f = mkf(MN_CLD, OP_NO, OP_NO, 3'd1);
				8'hFD: f = mkf(MN_STD, OP_NO, OP_NO, 3'd1);
				default: f = mkf(MN_BAD, OP_NO, OP_NO, 3'd1);
			endcase
		end
		return f;
	endfunction

	function automatic logic uses_modrm(input spec_t s);
		return s == OP_E8 || s == OP_E16 || s == OP_G8 || s == OP_G16 || s == OP_SR;
	endfunction

	function automatic logic [1:0] disp_bytes(input logic [7:0] modrm);
		logic [1:0] r;
		unique case (modrm[7:6])
			2'd1: r = 2'd1;
			2'd2: r = 2'd2;
			2'd0: r = (modrm[2:0] == 3'd6) ? 2'd2 : 2'd0;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic opnd_t mko(input logic [1:0] kind, input logic [4:0] base,
			input logic [4:0] index, input logic [31:0] value);
		opnd_t o;
		o.kind = kind;
		o.base = base;
		o.index = index;
		o.value = value;
		return o;
	endfunction

	function automatic opnd_t rm_operand(input logic [7:0] modrm, input logic [15:0] d16,
			input logic wide);
		opnd_t o;
		if (modrm[7:6] == 2'd3)
			o = mko(KIND_REG, wide ? bank16(modrm[2:0]) : bank8(modrm[2:0]), NOREG, 32'd0);
		else if (modrm[7:6] == 2'd0 && modrm[2:0] == 3'd6)
			o = mko(KIND_MEM, NOREG, NOREG, {16'd0, d16});
		else if (modrm[7:6] == 2'd0)
			o = mko(KIND_MEM, mem_base(modrm[2:0]), mem_index(modrm[2:0]), 32'd0);
		else if (modrm[7:6] == 2'd1)
			o = mko(KIND_MEM, mem_base(modrm[2:0]), mem_index(modrm[2:0]),
				{{24{d16[7]}}, d16[7:0]});
		else
			o = mko(KIND_MEM, mem_base(modrm[2:0]), mem_index(modrm[2:0]),
				{{16{d16[15]}}, d16});
		return o;
	endfunction

	function automatic opnd_t operand(input spec_t s, input logic [7:0] modrm,
			input logic [15:0] d16, input logic [15:0] imm, input logic [31:0] tgt8,
			input logic [31:0] tgt16);
		opnd_t o;
		case (s)
			OP_E8: o = rm_operand(modrm, d16, 1'b0);
			OP_E16: o = rm_operand(modrm, d16, 1'b1);
			OP_G8: o = mko(KIND_REG, bank8(modrm[5:3]), NOREG, 32'd0);
			OP_G16: o = mko(KIND_REG, bank16(modrm[5:3]), NOREG, 32'd0);
			OP_IU8: o = mko(KIND_IMM, NOREG, NOREG, {24'd0, imm[7:0]});
			OP_IS8: o = mko(KIND_IMM, NOREG, NOREG, {{24{imm[7]}}, imm[7:0]});
			OP_IZ16: o = mko(KIND_IMM, NOREG, NOREG, {16'd0, imm});
			OP_IS16: o = mko(KIND_IMM, NOREG, NOREG, {{16{imm[15]}}, imm});
			OP_R8: o = mko(KIND_IMM, NOREG, NOREG, tgt8);
			OP_R16: o = mko(KIND_IMM, NOREG, NOREG, tgt16);
			OP_MOF: o = mko(KIND_MEM, NOREG, NOREG, {16'd0, imm});
			default: begin
				if (s[4])
					o = mko(KIND_REG, {1'b0, s[3:0]}, NOREG, 32'd0);
				else
					o = mko(KIND_NONE, NOREG, NOREG, 32'd0);
			end
		endcase
		return o;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/x86_16bit_instruction_decoder.sv
// Three-stage pipelined decoder for one 16-bit x86 instruction per item.
// An item goes through the stage 1, 2 and 3 registers before its first result; then
// one result a cycle while result_stall is low. Stages 1 and 2 take later items, but
// the single result port sets the item rate: 3 results per item, 1 for a bad opcode.
// Reset (arst_n low) clears all stage valid bits and the result counter.
// Depends on x86dec_pkg.
`default_nettype none

module x86_16bit_instruction_decoder (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            instr_valid,
	output logic                 instr_stall,
	input  wire x86dec_pkg::in_t instr,
	output logic                 result_valid,
	input  wire logic            result_stall,
	output x86dec_pkg::out_t     result
);

	// stage 1: table lookup, length and immediate placement
	logic               valid_s1;
	x86dec_pkg::form_t  form_s1;
	logic [2:0]         len_s1;
	logic [15:0]        imm_s1;
	logic [7:0]         modrm_s1;
	logic [15:0]        d16_s1;
	logic [31:0]        addr_s1;

	// stage 2: decoded operands
	logic               valid_s2;
	x86dec_pkg::mn_t    mn_s2;
	logic               jmp_s2;
	logic               endf_s2;
	logic [2:0]         len_s2;
	x86dec_pkg::opnd_t  op_s2 [x86dec_pkg::NUM_SLOTS];

	// stage 3: result serializer
	logic               valid_s3;
	x86dec_pkg::mn_t    mn_s3;
	logic               jmp_s3;
	logic               endf_s3;
	logic [2:0]         len_s3;
	x86dec_pkg::opnd_t  op_s3 [x86dec_pkg::NUM_SLOTS];
	logic [1:0]         cnt_q;

	x86dec_pkg::form_t  form_c;
	logic               modrm_c;
	logic [1:0]         disp_c;
	logic [2:0]         len_c;
	logic [15:0]        imm_c;
	logic [31:0]        tgt8_c;
	logic [31:0]        tgt16_c;
	x86dec_pkg::opnd_t  op_c [x86dec_pkg::NUM_SLOTS];
	logic               bad_s3;
	logic               out_fire;
	logic               last_fire;
	logic               ld1;
	logic               ld2;
	logic               ld3;

	assign bad_s3    = (mn_s3 == x86dec_pkg::MN_BAD);
	assign out_fire  = valid_s3 && !result_stall;
	assign last_fire = out_fire && (bad_s3 || cnt_q == x86dec_pkg::SLOT_THIRD);
	assign ld3       = !valid_s3 || last_fire;
	assign ld2       = !valid_s2 || ld3;
	assign ld1       = !valid_s1 || ld2;
	assign instr_stall = !ld1;

	always_comb begin
		form_c  = x86dec_pkg::get_form(instr.opcode_byte);
		modrm_c = x86dec_pkg::uses_modrm(form_c.d) || x86dec_pkg::uses_modrm(form_c.s)
			|| x86dec_pkg::uses_modrm(form_c.t);
		disp_c  = modrm_c ? x86dec_pkg::disp_bytes(instr.next_byte) : 2'd0;
		len_c   = form_c.len + {1'b0, disp_c};
		// immediate follows the opcode, or the ModRM byte and displacement
		if (!modrm_c)
			imm_c = {instr.following_bytes[7:0], instr.next_byte};
		else begin
			case (disp_c)
				2'd0: imm_c = instr.following_bytes[15:0];
				2'd1: imm_c = instr.following_bytes[23:8];
				default: imm_c = instr.following_bytes[31:16];
			endcase
		end
	end

	always_comb begin
		tgt8_c  = addr_s1 + {29'd0, len_s1} + {{24{imm_s1[7]}}, imm_s1[7:0]};
		tgt16_c = addr_s1 + {29'd0, len_s1} + {{16{imm_s1[15]}}, imm_s1};
		op_c[0] = x86dec_pkg::operand(form_s1.d, modrm_s1, d16_s1, imm_s1, tgt8_c, tgt16_c);
		op_c[1] = x86dec_pkg::operand(form_s1.s, modrm_s1, d16_s1, imm_s1, tgt8_c, tgt16_c);
		if (form_s1.t == x86dec_pkg::OP_SM)
			op_c[2] = op_c[0];
		else
			op_c[2] = x86dec_pkg::operand(form_s1.t, modrm_s1, d16_s1, imm_s1, tgt8_c,
				tgt16_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (ld1)
				valid_s1 <= instr_valid;
			if (ld2)
				valid_s2 <= valid_s1;
			if (ld3) begin
				valid_s3 <= valid_s2;
				cnt_q    <= 2'd0;
			end else if (out_fire) begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld1 && instr_valid) begin
			form_s1  <= form_c;
			len_s1   <= len_c;
			imm_s1   <= imm_c;
			modrm_s1 <= instr.next_byte;
			d16_s1   <= instr.following_bytes[15:0];
			addr_s1  <= instr.instr_address;
		end
		if (ld2 && valid_s1) begin
			mn_s2   <= form_s1.mn;
			jmp_s2  <= form_s1.jmp;
			endf_s2 <= form_s1.endf;
			len_s2  <= len_s1;
			op_s2   <= op_c;
		end
		if (ld3 && valid_s2) begin
			mn_s3   <= mn_s2;
			jmp_s3  <= jmp_s2;
			endf_s3 <= endf_s2;
			len_s3  <= len_s2;
			op_s3   <= op_s2;
		end
	end

	assign result_valid = valid_s3;

	always_comb begin
		result.mnemonic  = mn_s3;
		result.is_jump   = jmp_s3;
		result.ends_flow = endf_s3;
		result.length    = len_s3;
		result.slot      = cnt_q;
		result.kind      = op_s3[cnt_q].kind;
		result.base_reg  = op_s3[cnt_q].base;
		result.index_reg = op_s3[cnt_q].index;
		result.value     = op_s3[cnt_q].value;
		result.last      = bad_s3 || cnt_q == x86dec_pkg::SLOT_THIRD;
	end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for x86_16bit_instruction_decoder: directed instructions, an
// opcode sweep and random items, each decoded by a local predictor and checked per result.
// Depends on x86dec_pkg for the item types and the mnemonic and operand-form enums.
`timescale 1ns / 100ps

module tb_top;
	import x86dec_pkg::*;

	typedef struct {
		mn_t   mn;
		spec_t d;
		spec_t s;
		spec_t t;
		int    len;
		bit    jmp;
		bit    endf;
	} op_form_s;

	typedef struct {
		logic [1:0]  kind;
		logic [4:0]  base;
		logic [4:0]  index;
		logic [31:0] value;
	} operand_s;

	localparam logic [4:0] REG8_CODE[8]  = '{5'd4, 5'd6, 5'd7, 5'd5, 5'd8, 5'd10, 5'd11, 5'd9};
	localparam logic [4:0] REG16_CODE[8] = '{5'd0, 5'd2, 5'd3, 5'd1, 5'd15, 5'd14, 5'd12, 5'd13};
	localparam logic [4:0] ADDR_BASE[8]  = '{5'd1, 5'd1, 5'd14, 5'd14, 5'd12, 5'd13, 5'd14, 5'd1};
	localparam logic [4:0] ADDR_INDEX[8] = '{5'd12, 5'd13, 5'd12, 5'd13, 5'd16, 5'd16, 5'd16,
		5'd16};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic instr_valid = 1'b0;
	logic instr_stall;
	in_t  instr = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_t result;

	out_t expected_ops[$];
	int   mismatches = 0;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;

	x86_16bit_instruction_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.instr_valid(instr_valid),
		.instr_stall(instr_stall),
		.instr(instr),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #1 clk = ~clk;

	function automatic op_form_s mkform(mn_t m, spec_t d, spec_t s, int len);
		op_form_s f;
		f.mn = m;
		f.d = d;
		f.s = s;
		f.t = OP_SM;
		f.len = len;
		f.jmp = 1'b0;
		f.endf = 1'b0;
		return f;
	endfunction

	function automatic op_form_s lookup_form(logic [7:0] op);
		op_form_s f;
		mn_t   alu[8] = '{MN_ADD, MN_OR, MN_ADC, MN_SBB, MN_AND, MN_SUB, MN_XOR, MN_CMP};
		mn_t   jcc[16] = '{MN_JO, MN_JNO, MN_JB, MN_JAE, MN_JE, MN_JNE, MN_JBE, MN_JA,
			MN_JS, MN_JNS, MN_JP, MN_JNP, MN_JL, MN_JGE, MN_JLE, MN_JG};
		mn_t   grp4[4] = '{MN_INC, MN_DEC, MN_PUSH, MN_POP};
		mn_t   loops[4] = '{MN_LOOPNE, MN_LOOPE, MN_LOOP, MN_JCXZ};
		spec_t r16[8] = '{OP_AX, OP_CX, OP_DX, OP_BX, OP_SP, OP_BP, OP_SI, OP_DI};
		spec_t r8[8] = '{OP_AL, OP_CL, OP_DL, OP_BL, OP_AH, OP_CH, OP_DH, OP_BH};
		f = mkform(MN_BAD, OP_NO, OP_NO, 1);
		if (op < 8'h40 && op[2:1] != 2'b11) begin
			case (op[2:0])
				3'd0: f = mkform(alu[op[5:3]], OP_E8, OP_G8, 2);
				3'd1: f = mkform(alu[op[5:3]], OP_E16, OP_G16, 2);
				3'd2: f = mkform(alu[op[5:3]], OP_G8, OP_E8, 2);
				3'd3: f = mkform(alu[op[5:3]], OP_G16, OP_E16, 2);
				3'd4: f = mkform(alu[op[5:3]], OP_AL, OP_IU8, 2);
				default: f = mkform(alu[op[5:3]], OP_AX, OP_IZ16, 3);
			endcase
		end else if (op >= 8'h40 && op < 8'h60) begin
			f = mkform(grp4[op[4:3]], r16[op[2:0]], OP_NO, 1);
		end else if (op[7:4] == 4'h7) begin
			f = mkform(jcc[op[3:0]], OP_R8, OP_NO, 2);
			f.jmp = 1'b1;
		end else if (op >= 8'hB0 && op < 8'hB8) begin
			f = mkform(MN_MOV, r8[op[2:0]], OP_IU8, 2);
		end else if (op >= 8'hB8) begin
			if (op < 8'hC0)
				f = mkform(MN_MOV, r16[op[2:0]], OP_IZ16, 3);
		end
		if (op >= 8'h91 && op <= 8'h97)
			f = mkform(MN_XCHG, OP_AX, r16[op[2:0]], 1);
		if (op >= 8'hE0 && op <= 8'hE3) begin
			f = mkform(loops[op[1:0]], OP_R8, OP_NO, 2);
			f.jmp = 1'b1;
		end
		case (op)
			8'h06, 8'h0E, 8'h16, 8'h1E: f = mkform(MN_PUSH, OP_NO, OP_NO, 1);
			8'h07, 8'h17, 8'h1F: f = mkform(MN_POP, OP_NO, OP_NO, 1);
			8'h27: f = mkform(MN_DAA, OP_NO, OP_NO, 1);
			8'h2E: f = mkform(MN_DAS, OP_NO, OP_NO, 1);
			8'h37: f = mkform(MN_AAA, OP_NO, OP_NO, 1);
			8'h3F: f = mkform(MN_AAS, OP_NO, OP_NO, 1);
			8'h60: f = mkform(MN_PUSHA, OP_NO, OP_NO, 1);
			8'h61: f = mkform(MN_POPA, OP_NO, OP_NO, 1);
			8'h68: f = mkform(MN_PUSH, OP_IZ16, OP_NO, 3);
			8'h69: begin
				f = mkform(MN_IMUL, OP_G16, OP_IZ16, 4);
				f.t = OP_E16;
			end
			8'h6A: f = mkform(MN_PUSH, OP_IS8, OP_NO, 2);
			8'h6B: begin
				f = mkform(MN_IMUL, OP_G16, OP_IS8, 3);
				f.t = OP_E16;
			end
			8'h84: f = mkform(MN_TEST, OP_E8, OP_G8, 2);
			8'h85: f = mkform(MN_TEST, OP_E16, OP_G16, 2);
			8'h86: f = mkform(MN_XCHG, OP_G8, OP_E8, 2);
			8'h87: f = mkform(MN_XCHG, OP_G16, OP_E16, 2);
			8'h88: f = mkform(MN_MOV, OP_E8, OP_G8, 2);
			8'h89: f = mkform(MN_MOV, OP_E16, OP_G16, 2);
			8'h8A: f = mkform(MN_MOV, OP_G8, OP_E8, 2);
			8'h8B: f = mkform(MN_MOV, OP_G16, OP_E16, 2);
			8'h8C: f = mkform(MN_MOV, OP_E16, OP_SR, 2);
			8'h8D: f = mkform(MN_LEA, OP_G16, OP_E16, 2);
			8'h8E: f = mkform(MN_MOV, OP_SR, OP_E16, 2);
			8'h8F: f = mkform(MN_POP, OP_E16, OP_NO, 2);
			8'h90: f = mkform(MN_NOP, OP_NO, OP_NO, 1);
			8'h9A: f = mkform(MN_CALL, OP_IZ16, OP_NO, 3);
			8'h9C: f = mkform(MN_PUSHF, OP_NO, OP_NO, 1);
			8'h9D: f = mkform(MN_POPF, OP_NO, OP_NO, 1);
			8'h9E: f = mkform(MN_SAHF, OP_NO, OP_NO, 1);
			8'h9F: f = mkform(MN_LAHF, OP_NO, OP_NO, 1);
			8'hA0: f = mkform(MN_MOV, OP_AL, OP_MOF, 3);
			8'hA1: f = mkform(MN_MOV, OP_AX, OP_MOF, 3);
			8'hA2: f = mkform(MN_MOV, OP_MOF, OP_AL, 3);
			8'hA3: f = mkform(MN_MOV, OP_MOF, OP_AX, 3);
			8'hA4: f = mkform(MN_MOVSB, OP_NO, OP_NO, 1);
			8'hA5: f = mkform(MN_MOVSW, OP_NO, OP_NO, 1);
			8'hA6: f = mkform(MN_CMPSB, OP_NO, OP_NO, 1);
			8'hA7: f = mkform(MN_CMPSW, OP_NO, OP_NO, 1);
			8'hA8: f = mkform(MN_TEST, OP_AL, OP_IU8, 2);
			8'hA9: f = mkform(MN_TEST, OP_AX, OP_IZ16, 3);
			8'hAA: f = mkform(MN_STOSB, OP_NO, OP_NO, 1);
			8'hAB: f = mkform(MN_STOSW, OP_NO, OP_NO, 1);
			8'hAC: f = mkform(MN_LODSB, OP_NO, OP_NO, 1);
			8'hAD: f = mkform(MN_LODSW, OP_NO, OP_NO, 1);
			8'hAE: f = mkform(MN_SCASB, OP_NO, OP_NO, 1);
			8'hAF: f = mkform(MN_SCASW, OP_NO, OP_NO, 1);
			8'hC2: f = mkform(MN_RET, OP_IS16, OP_NO, 3);
			8'hC3: f = mkform(MN_RET, OP_NO, OP_NO, 1);
			8'hC4: f = mkform(MN_LES, OP_G16, OP_E16, 2);
			8'hC5: f = mkform(MN_LDS, OP_G16, OP_E16, 2);
			8'hC6: f = mkform(MN_MOV, OP_E8, OP_IU8, 3);
			8'hC7: f = mkform(MN_MOV, OP_E16, OP_IS16, 4);
			8'hCA: f = mkform(MN_RETF, OP_IS16, OP_NO, 3);
			8'hCB: f = mkform(MN_RETF, OP_NO, OP_NO, 1);
			8'hCC: f = mkform(MN_INT3, OP_NO, OP_NO, 1);
			8'hCD: f = mkform(MN_INT, OP_IU8, OP_NO, 2);
			8'hCE: f = mkform(MN_INTO, OP_NO, OP_NO, 1);
			8'hCF: f = mkform(MN_IRET, OP_NO, OP_NO, 1);
			8'hD4: f = mkform(MN_AAM, OP_IU8, OP_NO, 2);
			8'hD5: f = mkform(MN_AAD, OP_IU8, OP_NO, 2);
			8'hD7: f = mkform(MN_XLATB, OP_NO, OP_NO, 1);
			8'hE4: f = mkform(MN_IN, OP_AL, OP_IU8, 2);
			8'hE5: f = mkform(MN_IN, OP_AX, OP_IU8, 2);
			8'hE6: f = mkform(MN_OUT, OP_IU8, OP_AL, 2);
			8'hE7: f = mkform(MN_OUT, OP_IU8, OP_AX, 2);
			8'hE8: f = mkform(MN_CALL, OP_R16, OP_NO, 3);
			8'hE9: f = mkform(MN_JMP, OP_R16, OP_NO, 3);
			8'hEA: f = mkform(MN_JMP, OP_IZ16, OP_NO, 3);
			8'hEB: f = mkform(MN_JMP, OP_R8, OP_NO, 2);
			8'hEC: f = mkform(MN_IN, OP_AL, OP_DX, 1);
			8'hED: f = mkform(MN_IN, OP_AX, OP_DX, 1);
			8'hEE: f = mkform(MN_OUT, OP_DX, OP_AL, 1);
			8'hEF: f = mkform(MN_OUT, OP_DX, OP_AX, 1);
			8'hF4: f = mkform(MN_HLT, OP_NO, OP_NO, 1);
			8'hF5: f = mkform(MN_CMC, OP_NO, OP_NO, 1);
			8'hF8: f = mkform(MN_CLC, OP_NO, OP_NO, 1);
			8'hF9: f = mkform(MN_STC, OP_NO, OP_NO, 1);
			8'hFA: f = mkform(MN_CLI, OP_NO, OP_NO, 1);
			8'hFB: f = mkform(MN_STI, OP_NO, OP_NO, 1);
			8'hFC: f = mkform(MN_CLD, OP_NO, OP_NO, 1);
			8'hFD: f = mkform(MN_STD, OP_NO, OP_NO, 1);
			default: ;
		endcase
		// Flow flags for returns and unconditional jumps
		if (op inside {8'hC2, 8'hC3, 8'hCA, 8'hCB, 8'hE9, 8'hEA, 8'hEB})
			f.endf = 1'b1;
		if (op inside {8'hE9, 8'hEA, 8'hEB})
			f.jmp = 1'b1;
		return f;
	endfunction

	function automatic bit takes_modrm(spec_t s);
		return s inside {OP_E8, OP_E16, OP_G8, OP_G16, OP_SR};
	endfunction

	function automatic operand_s decode_operand(spec_t s, logic [63:0] bytes, int p,
			logic [31:0] addr, int len);
		operand_s o;
		logic [7:0]  modrm;
		logic [15:0] disp;
		logic [7:0]  imm8;
		logic [15:0] imm16;
		logic [1:0]  mod;
		logic [2:0]  rm;
		modrm = bytes[15:8];
		disp = bytes[31:16];
		imm8 = bytes[8*p +: 8];
		imm16 = bytes[8*p +: 16];
		mod = modrm[7:6];
		rm = modrm[2:0];
		o.kind = KIND_NONE;
		o.base = NOREG;
		o.index = NOREG;
		o.value = '0;
		if (s == OP_E8 || s == OP_E16) begin
			if (mod == 2'd3) begin
				o.kind = KIND_REG;
				o.base = (s == OP_E16) ? REG16_CODE[rm] : REG8_CODE[rm];
			end else begin
				o.kind = KIND_MEM;
				if (mod == 2'd0 && rm == 3'd6) begin
					o.value = {16'd0, disp};
				end else begin
					o.base = ADDR_BASE[rm];
					o.index = ADDR_INDEX[rm];
					if (mod == 2'd1)
						o.value = {{24{disp[7]}}, disp[7:0]};
					else if (mod == 2'd2)
						o.value = {{16{disp[15]}}, disp};
				end
			end
		end else if (s == OP_G8 || s == OP_G16) begin
			o.kind = KIND_REG;
			o.base = (s == OP_G16) ? REG16_CODE[modrm[5:3]] : REG8_CODE[modrm[5:3]];
		end else if (s inside {OP_IU8, OP_IS8, OP_IZ16, OP_IS16, OP_R8, OP_R16}) begin
			o.kind = KIND_IMM;
			case (s)
				OP_IU8: o.value = {24'd0, imm8};
				OP_IS8: o.value = {{24{imm8[7]}}, imm8};
				OP_IZ16: o.value = {16'd0, imm16};
				OP_IS16: o.value = {{16{imm16[15]}}, imm16};
				OP_R8: o.value = addr + len + {{24{imm8[7]}}, imm8};
				default: o.value = addr + len + {{16{imm16[15]}}, imm16};
			endcase
		end else if (s == OP_MOF) begin
			o.kind = KIND_MEM;
			o.value = {16'd0, imm16};
		end else if (s >= OP_AX) begin
			o.kind = KIND_REG;
			o.base = s - 5'd16;
		end
		return o;
	endfunction

	// Push the operand results one instruction yields onto the expected queue
	function automatic void predict_decode(in_t it);
		op_form_s   f;
		logic [63:0] bytes;
		int         len;
		int         p;
		operand_s   ops[3];
		out_t       r;
		f = lookup_form(it.opcode_byte);
		bytes = {16'd0, it.following_bytes, it.next_byte, it.opcode_byte};
		len = f.len;
		p = 1;
		if (f.mn == MN_BAD) begin
			r = '0;
			r.mnemonic = MN_BAD;
			r.length = 3'd1;
			r.kind = KIND_NONE;
			r.base_reg = NOREG;
			r.index_reg = NOREG;
			r.last = 1'b1;
			expected_ops.push_back(r);
			return;
		end
		if (takes_modrm(f.d) || takes_modrm(f.s) || takes_modrm(f.t)) begin
			if (it.next_byte[7:6] == 2'd1)
				len += 1;
			else if (it.next_byte[7:6] == 2'd2 ||
					(it.next_byte[7:6] == 2'd0 && it.next_byte[2:0] == 3'd6))
				len += 2;
			p = 2 + len - f.len;
		end
		ops[0] = decode_operand(f.d, bytes, p, it.instr_address, len);
		ops[1] = decode_operand(f.s, bytes, p, it.instr_address, len);
		ops[2] = (f.t == OP_SM) ? ops[0] : decode_operand(f.t, bytes, p, it.instr_address, len);
		for (int k = 0; k < 3; k++) begin
			r.mnemonic = f.mn;
			r.is_jump = f.jmp;
			r.ends_flow = f.endf;
			r.length = len[2:0];
			r.slot = k[1:0];
			r.kind = ops[k].kind;
			r.base_reg = ops[k].base;
			r.index_reg = ops[k].index;
			r.value = ops[k].value;
			r.last = (k == 2);
			expected_ops.push_back(r);
		end
	endfunction

	task automatic send_instr(in_t it);
		// Stay idle while a random draw falls below the set idle percentage
		while ($urandom_range(99) < tx_idle_pct) begin
			instr_valid <= 1'b0;
			@(posedge clk);
		end
		instr <= it;
		instr_valid <= 1'b1;
		@(posedge clk);
		while (instr_stall)
			@(posedge clk);
		predict_decode(it);
	endtask

	task automatic send_bytes(logic [7:0] op, logic [7:0] nb, logic [31:0] fb,
			logic [31:0] addr);
		in_t it;
		it.opcode_byte = op;
		it.next_byte = nb;
		it.following_bytes = fb;
		it.instr_address = addr;
		send_instr(it);
	endtask

	function automatic in_t random_instr(logic [7:0] op);
		in_t it;
		it.opcode_byte = op;
		it.next_byte = $urandom_range(255);
		it.following_bytes = $urandom;
		it.instr_address = $urandom;
		// Hit the address extremes now and then to exercise target wrap
		case ($urandom_range(7))
			0: it.instr_address = 32'hFFFF_FFFF;
			1: it.instr_address = 32'h0;
			default: ;
		endcase
		return it;
	endfunction

	task automatic test_directed();
		send_bytes(8'h00, 8'h00, 32'h0, 32'h0);
		send_bytes(8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_bytes(8'h0F, 8'h12, 32'h1234_5678, 32'h100);
		send_bytes(8'h8B, 8'h06, 32'hFFFF_BEEF, 32'h0);
		send_bytes(8'h01, 8'h47, 32'h0000_0080, 32'h0);
		send_bytes(8'h03, 8'h87, 32'h0000_8000, 32'h0);
		send_bytes(8'h88, 8'hC0, 32'h0, 32'h0);
		send_bytes(8'h89, 8'hFF, 32'h0, 32'h0);
		send_bytes(8'h8C, 8'h9E, 32'h1122_3344, 32'h0);
		send_bytes(8'h8E, 8'h46, 32'hFFFF_FF7F, 32'h0);
		send_bytes(8'hA0, 8'h34, 32'hFFFF_FF12, 32'h0);
		send_bytes(8'hA3, 8'hFF, 32'h0000_00FF, 32'h0);
		send_bytes(8'h9A, 8'h00, 32'hFFFF_FF80, 32'h0);
		send_bytes(8'hEA, 8'hFF, 32'h0000_00FF, 32'h0);
		send_bytes(8'hC6, 8'hB8, 32'h00AB_8001, 32'h0);
		send_bytes(8'hC7, 8'h06, 32'h8000_FFFF, 32'h0);
		send_bytes(8'h69, 8'h36, 32'hFFFF_1234, 32'h0);
		send_bytes(8'h6B, 8'hDB, 32'h0000_0080, 32'h0);
		send_bytes(8'hEB, 8'h7F, 32'h0, 32'hFFFF_FFFF);
		send_bytes(8'h74, 8'h80, 32'h0, 32'h0);
		send_bytes(8'hE9, 8'h00, 32'h0000_0080, 32'h0000_0010);
		send_bytes(8'hE8, 8'hFD, 32'h0000_00FF, 32'hFFFF_FFF0);
		send_bytes(8'hC2, 8'hFE, 32'h0000_00FF, 32'h0);
		send_bytes(8'h8F, 8'h38, 32'h0, 32'h0);
		send_bytes(8'hC3, 8'h00, 32'h0, 32'h0);
	endtask

	task automatic test_opcode_sweep();
		for (int op = 0; op < 256; op++)
			send_instr(random_instr(op[7:0]));
	endtask

	task automatic test_random(int count);
		for (int n = 0; n < count; n++)
			send_instr(random_instr($urandom_range(255)));
	endtask

	always @(posedge clk) begin
		if (arst_n)
			result_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_ops.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %p", result);
			end else begin
				want = expected_ops.pop_front();
				if (result.mnemonic !== want.mnemonic || result.is_jump !== want.is_jump ||
						result.ends_flow !== want.ends_flow || result.length !== want.length ||
						result.slot !== want.slot || result.kind !== want.kind ||
						result.base_reg !== want.base_reg ||
						result.index_reg !== want.index_reg ||
						result.value !== want.value || result.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", want, result);
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_pct = 17;
		rx_idle_pct = 52;
		test_directed();
		test_opcode_sweep();
		tx_idle_pct = 52;
		rx_idle_pct = 17;
		test_random(50);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random(40);
		instr_valid <= 1'b0;
		while (expected_ops.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_ops.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#400000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: x86_16bit_instruction_decoder.f
rtl/core/x86dec_pkg.sv
rtl/core/x86_16bit_instruction_decoder.sv
tb/tb_top.sv
